// ----- hw/rtl/sfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder package
// Framing byte codes, result kinds, error codes and shared types.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int LenOutW = 16;
	localparam int MaxLenW = 16;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [MaxLenW-1:0] MAX_LEN_RESET = 16'd1006;

	localparam logic REQ_BYTE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_FRAME = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_TIMEOUT  = 2'd0;
	localparam logic [1:0] ERR_NO_START = 2'd1;
	localparam logic [1:0] ERR_BAD_ESC  = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_FRAME = 3'b010,
		PH_ESC   = 3'b100
	} phase_t;

	typedef struct packed {
		logic               valid;
		logic [1:0]         kind;
		logic [7:0]         data;
		logic [LenOutW-1:0] len;
		logic [1:0]         err;
	} res_t;

endpackage

// ----- hw/rtl/slip_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder
// Strict SLIP receive deframer: data bytes, frame lengths and errors.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries a received byte or a receive
// timeout event. Output channel (out_valid / out_stall) carries at most one
// result per item: a decoded data byte, a frame length or an error code.
// max_frame_len is written with max_len_we / max_len_wdata. The user must
// write it only while idle; the block itself does not enforce this.
// Each item is captured in an input register, decoded in one pass against
// the frame state and written to the result register, one item per cycle
// sustained while the receiver does not stall.
// Items that give no result still pass the decode stage and give no output.
// Reset empties both registers, returns the decoder to idle with a zero
// count and sets max_frame_len to 1006.
// A stalled receiver holds the result register; the decode stage then holds
// its item and in_stall rises in the same cycle, so no transfer is lost.
// ----------------------------------------------------------------------------
module slip_frame_decoder_top #(
	parameter int LEN_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          max_len_we,
	input  logic [sfd_pkg::MaxLenW-1:0]   max_len_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    res_kind,
	output logic [7:0]                    data_byte,
	output logic [sfd_pkg::LenOutW-1:0]   frame_len,
	output logic [1:0]                    error_code
);

	logic [sfd_pkg::MaxLenW-1:0] max_len_q;
	logic                        valid_s1;
	logic                        req_type_s1;
	logic [7:0]                  rx_byte_s1;
	sfd_pkg::phase_t             phase_q;
	logic [LEN_BITS-1:0]         cnt_q;
	sfd_pkg::phase_t             phase_nxt;
	logic [LEN_BITS-1:0]         cnt_nxt;
	sfd_pkg::res_t               res;
	logic                        out_free;
	logic                        advance;
	logic                        in_xfer;

	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= sfd_pkg::MAX_LEN_RESET;
		end else if (max_len_we) begin
			max_len_q <= max_len_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_type_s1 <= req_type;
			rx_byte_s1  <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfd_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	sfd_step #(
		.LEN_BITS (LEN_BITS)
	) u_step (
		.phase_q   (phase_q),
		.cnt_q     (cnt_q),
		.max_len   (max_len_q),
		.req_type  (req_type_s1),
		.rx_byte   (rx_byte_s1),
		.phase_nxt (phase_nxt),
		.cnt_nxt   (cnt_nxt),
		.res       (res)
	);

	sfd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.res        (res),
		.out_stall  (out_stall),
		.free       (out_free),
		.out_valid  (out_valid),
		.res_kind   (res_kind),
		.data_byte  (data_byte),
		.frame_len  (frame_len),
		.error_code (error_code)
	);

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sfd_pkg::PH_IDLE) |-> (cnt_q == '0))
		else $error("byte count not cleared while idle");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a held item");

	a_held_item_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=>
		(valid_s1 && $stable(req_type_s1) && $stable(rx_byte_s1)))
		else $error("decode stage item lost while output stalled");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (res_kind == sfd_pkg::KIND_DATA ||
			res_kind == sfd_pkg::KIND_FRAME || res_kind == sfd_pkg::KIND_ERROR))
		else $error("result register holds an unknown kind");

endmodule

// ----- hw/rtl/sfd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder step logic
// Next phase, next byte count and result for one registered input item.
// ----------------------------------------------------------------------------
module sfd_step #(
	parameter int LEN_BITS = 16
) (
	input  sfd_pkg::phase_t                phase_q,
	input  logic [LEN_BITS-1:0]            cnt_q,
	input  logic [sfd_pkg::MaxLenW-1:0]    max_len,
	input  logic                           req_type,
	input  logic [7:0]                     rx_byte,
	output sfd_pkg::phase_t                phase_nxt,
	output logic [LEN_BITS-1:0]            cnt_nxt,
	output sfd_pkg::res_t                  res
);

	localparam int ExtW = LEN_BITS + sfd_pkg::LenOutW;

	logic [ExtW-1:0] cnt_ext;
	logic [ExtW-1:0] max_ext;
	logic [ExtW-1:0] cap_ext;
	logic [ExtW-1:0] limit;
	logic            ovf;
	logic            emit_en;
	logic [7:0]      emit_byte;

	assign cnt_ext = {{sfd_pkg::LenOutW{1'b0}}, cnt_q};
	assign max_ext = {{(ExtW - sfd_pkg::MaxLenW){1'b0}}, max_len};
	assign cap_ext = {{sfd_pkg::LenOutW{1'b0}}, {LEN_BITS{1'b1}}};
	assign limit   = (max_ext > cap_ext) ? cap_ext : max_ext;
	assign ovf     = (cnt_ext >= limit);

	always_comb begin
		phase_nxt = phase_q;
		cnt_nxt   = cnt_q;
		res       = '0;
		emit_en   = 1'b0;
		emit_byte = rx_byte;

		if (req_type == sfd_pkg::REQ_TIMEOUT) begin
			phase_nxt = sfd_pkg::PH_IDLE;
			cnt_nxt   = '0;
			res.valid = 1'b1;
			res.kind  = sfd_pkg::KIND_ERROR;
			res.err   = sfd_pkg::ERR_TIMEOUT;
		end else begin
			case (phase_q)
				sfd_pkg::PH_FRAME: begin
					if (rx_byte == sfd_pkg::SLIP_END) begin
						phase_nxt = sfd_pkg::PH_IDLE;
						cnt_nxt   = '0;
						res.valid = 1'b1;
						res.kind  = sfd_pkg::KIND_FRAME;
						res.len   = cnt_ext[sfd_pkg::LenOutW-1:0];
					end else if (rx_byte == sfd_pkg::SLIP_ESC) begin
						phase_nxt = sfd_pkg::PH_ESC;
					end else begin
						emit_en = 1'b1;
					end
				end
				sfd_pkg::PH_ESC: begin
					if (rx_byte == sfd_pkg::SLIP_ESC_END) begin
						emit_en   = 1'b1;
						emit_byte = sfd_pkg::SLIP_END;
					end else if (rx_byte == sfd_pkg::SLIP_ESC_ESC) begin
						emit_en   = 1'b1;
						emit_byte = sfd_pkg::SLIP_ESC;
					end else begin
						phase_nxt = sfd_pkg::PH_IDLE;
						cnt_nxt   = '0;
						res.valid = 1'b1;
						res.kind  = sfd_pkg::KIND_ERROR;
						res.err   = sfd_pkg::ERR_BAD_ESC;
					end
				end
				default: begin
					if (rx_byte == sfd_pkg::SLIP_END) begin
						phase_nxt = sfd_pkg::PH_FRAME;
						cnt_nxt   = '0;
					end else begin
						phase_nxt = sfd_pkg::PH_IDLE;
						cnt_nxt   = '0;
						res.valid = 1'b1;
						res.kind  = sfd_pkg::KIND_ERROR;
						res.err   = sfd_pkg::ERR_NO_START;
					end
				end
			endcase

			if (emit_en) begin
				res.valid = 1'b1;
				if (ovf) begin
					phase_nxt = sfd_pkg::PH_IDLE;
					cnt_nxt   = '0;
					res.kind  = sfd_pkg::KIND_ERROR;
					res.err   = sfd_pkg::ERR_OVERFLOW;
				end else begin
					phase_nxt = sfd_pkg::PH_FRAME;
					cnt_nxt   = cnt_q + LEN_BITS'(1);
					res.kind  = sfd_pkg::KIND_DATA;
					res.data  = emit_byte;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/sfd_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder result register
// Holds one result for the output channel and reports when it can take another.
// ----------------------------------------------------------------------------
module sfd_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  sfd_pkg::res_t                 res,
	input  logic                          out_stall,
	output logic                          free,
	output logic                          out_valid,
	output logic [1:0]                    res_kind,
	output logic [7:0]                    data_byte,
	output logic [sfd_pkg::LenOutW-1:0]   frame_len,
	output logic [1:0]                    error_code
);

	logic                        valid_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  data_q;
	logic [sfd_pkg::LenOutW-1:0] len_q;
	logic [1:0]                  err_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res.valid) begin
			kind_q <= res.kind;
			data_q <= res.data;
			len_q  <= res.len;
			err_q  <= res.err;
		end
	end

	assign out_valid  = valid_q;
	assign res_kind   = kind_q;
	assign data_byte  = data_q;
	assign frame_len  = len_q;
	assign error_code = err_q;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SLIP frame decoder testbench
// Drives directed and random streams of received bytes and timeouts into the
// decoder. The source and the sink pause at random. A local deframing model
// predicts each result, and every output transfer is checked field by field
// over several maximum frame length settings.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LEN_BITS = 16;
	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int PHASE_EVENTS = 166;
	localparam int NUM_PHASES = 8;
	localparam longint COUNT_CAP = (64'd1 << LEN_BITS) - 1;

	typedef struct packed {
		logic       kind_timeout;
		logic [7:0] code;
	} rx_event_t;

	typedef struct packed {
		logic [1:0]                  kind;
		logic [7:0]                  data;
		logic [sfd_pkg::LenOutW-1:0] len;
		logic [1:0]                  err;
	} decoded_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        max_len_we = 1'b0;
	logic [sfd_pkg::MaxLenW-1:0] max_len_wdata = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        req_type = sfd_pkg::REQ_BYTE;
	logic [7:0]                  rx_byte = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  res_kind;
	logic [7:0]                  data_byte;
	logic [sfd_pkg::LenOutW-1:0] frame_len;
	logic [1:0]                  error_code;

	rx_event_t rx_backlog[$];
	decoded_t  decoded_due[$];

	logic [sfd_pkg::MaxLenW-1:0] max_len_model = sfd_pkg::MAX_LEN_RESET;
	sfd_pkg::phase_t             phase_model = sfd_pkg::PH_IDLE;
	logic [LEN_BITS-1:0]         count_model = '0;

	logic in_xfer = 1'b0;
	logic gaps_on = 1'b1;
	logic long_hold = 1'b0;
	logic hold_trigger = 1'b0;
	int   send_wait = 0;
	int   stall_left = 0;
	int   events_queued = 0;
	int   fault_count = 0;

	slip_frame_decoder_top #(
		.LEN_BITS(LEN_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.max_len_we(max_len_we),
		.max_len_wdata(max_len_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res_kind(res_kind),
		.data_byte(data_byte),
		.frame_len(frame_len),
		.error_code(error_code)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// deframing model
	function automatic void deframe_error(input logic [1:0] code, output decoded_t res);
		phase_model = sfd_pkg::PH_IDLE;
		count_model = '0;
		res = '0;
		res.kind = sfd_pkg::KIND_ERROR;
		res.err = code;
	endfunction

	function automatic void accept_payload(input logic [7:0] value, output decoded_t res);
		longint limit;
		limit = max_len_model;
		if (limit > COUNT_CAP)
			limit = COUNT_CAP;
		if (count_model >= limit) begin
			deframe_error(sfd_pkg::ERR_OVERFLOW, res);
		end else begin
			count_model = count_model + LEN_BITS'(1);
			phase_model = sfd_pkg::PH_FRAME;
			res = '0;
			res.kind = sfd_pkg::KIND_DATA;
			res.data = value;
		end
	endfunction

	function automatic bit deframe_event(input rx_event_t ev, output decoded_t res);
		bit produced;
		produced = 1'b1;
		res = '0;
		if (ev.kind_timeout == sfd_pkg::REQ_TIMEOUT) begin
			deframe_error(sfd_pkg::ERR_TIMEOUT, res);
		end else begin
			case (phase_model)
				sfd_pkg::PH_FRAME: begin
					if (ev.code == sfd_pkg::SLIP_END) begin
						res.kind = sfd_pkg::KIND_FRAME;
						res.len = sfd_pkg::LenOutW'(count_model);
						phase_model = sfd_pkg::PH_IDLE;
						count_model = '0;
					end else if (ev.code == sfd_pkg::SLIP_ESC) begin
						phase_model = sfd_pkg::PH_ESC;
						produced = 1'b0;
					end else begin
						accept_payload(ev.code, res);
					end
				end
				sfd_pkg::PH_ESC: begin
					if (ev.code == sfd_pkg::SLIP_ESC_END)
						accept_payload(sfd_pkg::SLIP_END, res);
					else if (ev.code == sfd_pkg::SLIP_ESC_ESC)
						accept_payload(sfd_pkg::SLIP_ESC, res);
					else
						deframe_error(sfd_pkg::ERR_BAD_ESC, res);
				end
				default: begin
					if (ev.code == sfd_pkg::SLIP_END) begin
						phase_model = sfd_pkg::PH_FRAME;
						count_model = '0;
						produced = 1'b0;
					end else begin
						deframe_error(sfd_pkg::ERR_NO_START, res);
					end
				end
			endcase
		end
		return produced;
	endfunction

	// stimulus
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_event(input logic kind_timeout, input logic [7:0] code);
		rx_event_t ev;
		ev.kind_timeout = kind_timeout;
		ev.code = code;
		rx_backlog.push_back(ev);
		events_queued++;
	endfunction

	function automatic int pick_frame_len();
		if (max_len_model <= 40)
			return $urandom_range(0, int'(max_len_model) + 2);
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(41, 150);
		return $urandom_range(0, 24);
	endfunction

	// stop an overlong frame at the byte that overflows, so the stream stays in step
	function automatic void push_frame(input int n);
		int         r;
		int         stop_at;
		logic [7:0] b;
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		stop_at = (n > int'(max_len_model)) ? int'(max_len_model) + 1 : n;
		for (int k = 0; k < stop_at; k++) begin
			r = $urandom_range(0, 99);
			b = (r < 10) ? sfd_pkg::SLIP_END : (r < 20) ? sfd_pkg::SLIP_ESC : 8'($urandom);
			if (b == sfd_pkg::SLIP_END) begin
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC_END);
			end else if (b == sfd_pkg::SLIP_ESC) begin
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC_ESC);
			end else begin
				push_event(sfd_pkg::REQ_BYTE, b);
			end
		end
		if (stop_at == n) begin
			r = $urandom_range(0, 99);
			if (r < 84) begin
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
			end else if (r < 90) begin
				push_event(sfd_pkg::REQ_TIMEOUT, 8'($urandom));
			end else if (r < 93) begin
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
				push_event(sfd_pkg::REQ_TIMEOUT, 8'($urandom));
			end else begin
				b = ($urandom_range(0, 1) == 0) ? sfd_pkg::SLIP_END : 8'($urandom);
				if (b == sfd_pkg::SLIP_ESC_END || b == sfd_pkg::SLIP_ESC_ESC)
					b = 8'h00;
				push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
				push_event(sfd_pkg::REQ_BYTE, b);
			end
		end
	endfunction

	function automatic void push_noise();
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			push_event(sfd_pkg::REQ_TIMEOUT, 8'($urandom));
		end else if (r < 45) begin
			push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
			push_event(sfd_pkg::REQ_TIMEOUT, 8'($urandom));
		end else begin
			b = 8'($urandom);
			if (b == sfd_pkg::SLIP_END)
				b = sfd_pkg::SLIP_ESC;
			push_event(sfd_pkg::REQ_BYTE, b);
		end
	endfunction

	task automatic settle();
		while (rx_backlog.size() != 0 || in_valid || decoded_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_max_len(input logic [sfd_pkg::MaxLenW-1:0] value);
		@(negedge clk);
		max_len_we <= 1'b1;
		max_len_wdata <= value;
		@(negedge clk);
		max_len_we <= 1'b0;
		max_len_model = value;
	endtask

	// driver
	always @(negedge clk) begin : feed
		rx_event_t ev;
		if (arst_n && (!in_valid || in_xfer)) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (rx_backlog.size() > 0) begin
				ev = rx_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= ev.kind_timeout;
				rx_byte <= ev.code;
				send_wait = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sink pacing
	always @(negedge clk) begin : sink_pace
		int g;
		if (long_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			g = pick_gap();
			out_stall <= (g > 0);
			stall_left = (g > 0) ? g - 1 : 0;
		end
	end

	initial begin : rx_hold_off
		wait (hold_trigger);
		@(negedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(negedge clk);
		long_hold <= 1'b0;
	end

	// monitor: capture input transfers, then check output transfers
	always @(posedge clk) begin : monitor
		rx_event_t ev;
		decoded_t  res;
		decoded_t  want;
		in_xfer <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			ev.kind_timeout = req_type;
			ev.code = rx_byte;
			if (deframe_event(ev, res))
				decoded_due.push_back(res);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_due.size() == 0) begin
				$error("unexpected result: res_kind %0d data_byte %0d frame_len %0d error_code %0d",
					res_kind, data_byte, frame_len, error_code);
				fault_count++;
			end else begin
				want = decoded_due.pop_front();
				if (res_kind !== want.kind) begin
					$error("res_kind: expected %0d, actual %0d", want.kind, res_kind);
					fault_count++;
				end
				if (data_byte !== want.data) begin
					$error("data_byte: expected %0d, actual %0d", want.data, data_byte);
					fault_count++;
				end
				if (frame_len !== want.len) begin
					$error("frame_len: expected %0d, actual %0d", want.len, frame_len);
					fault_count++;
				end
				if (error_code !== want.err) begin
					$error("error_code: expected %0d, actual %0d", want.err, error_code);
					fault_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [sfd_pkg::MaxLenW-1:0] cfg_plan [NUM_PHASES];
		int                          target;
		cfg_plan = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'($urandom_range(3, 60)), 16'd5,
			sfd_pkg::MAX_LEN_RESET, 16'($urandom_range(6, 40))};
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		push_event(sfd_pkg::REQ_TIMEOUT, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, 8'h00);
		push_event(sfd_pkg::REQ_BYTE, 8'hFF);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, 8'h00);
		push_event(sfd_pkg::REQ_BYTE, 8'hFF);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC_ESC);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);
		push_event(sfd_pkg::REQ_TIMEOUT, 8'h55);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_END);
		push_event(sfd_pkg::REQ_BYTE, 8'hAA);
		push_event(sfd_pkg::REQ_TIMEOUT, 8'h00);
		push_event(sfd_pkg::REQ_BYTE, sfd_pkg::SLIP_ESC);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_max_len(cfg_plan[p]);
			gaps_on = (p != 2) && (p != 4);
			target = events_queued + PHASE_EVENTS;
			while (events_queued < target) begin
				if ($urandom_range(0, 99) < 80)
					push_frame(pick_frame_len());
				else
					push_noise();
			end
			if (p == 4)
				hold_trigger = 1'b1;
		end
		settle();

		if (fault_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_step.sv
hw/rtl/sfd_out_reg.sv
hw/rtl/slip_frame_decoder_top.sv
test/testbench.sv
